// File: sv/priority_round_robin_thread_scheduler_defines.svh
// Assertion helpers for the scheduler
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// Assert a property on the block clock, off during reset
`define PRRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert a property that holds during reset too
`define PRRTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/prrts_pkg.sv
`timescale 1ns / 1ps
package prrts_pkg;

  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_YIELD   = 4'd1;
  localparam logic [3:0] OP_START   = 4'd2;
  localparam logic [3:0] OP_STOP    = 4'd3;
  localparam logic [3:0] OP_SETPRIO = 4'd4;
  localparam logic [3:0] OP_SLEEP   = 4'd5;
  localparam logic [3:0] OP_EXIT    = 4'd6;
  localparam logic [3:0] OP_CREATE  = 4'd7;
  localparam logic [3:0] OP_DESTROY = 4'd8;

  localparam logic [1:0] ST_STOPPED  = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;
  localparam logic [1:0] ST_SLEEPING = 2'd3;

  typedef enum logic [1:0] {
    RULE_CURRENT = 2'd0,
    RULE_OTHER   = 2'd1,
    RULE_ANY     = 2'd2
  } rule_e;

  localparam logic [0:0] REG_MIN_PRIO = 1'b0;
  localparam logic [0:0] REG_MAX_PRIO = 1'b1;

  localparam int BOOST_AMOUNT = 100000;
  localparam int EFF_W        = 19;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the event and apply the op
    logic cnt_step; // countdown one slot at the scan index
    logic best_step;// fold one slot into the band maximum
    logic sel_step; // round robin test at the scan index
    logic finish;   // commit pick and emit result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic quick;    // keep-current satisfied
    logic found;    // round robin hit at this index
  } sts_t;

endpackage

// File: sv/prrts_datapath.sv
`timescale 1ns / 1ps
module prrts_datapath #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prrts_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]      idx_i,
  output prrts_pkg::sts_t                   sts_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic [3:0]                        op_i,
  input  logic [3:0]                        target_slot_i,
  input  logic signed [15:0]                new_priority_i,
  input  logic [31:0]                       sleep_time_i,
  input  logic [31:0]                       elapsed_i,
  output logic [3:0]                        next_slot_o,
  output logic                              run_idle_o
);
  localparam int IW = $clog2(NUM_SLOTS);

  logic signed [15:0] min_q, max_q;
  logic [NUM_SLOTS-1:0] used_q, boost_q;
  logic [1:0]           state_q [NUM_SLOTS];
  logic signed [15:0]   prio_q  [NUM_SLOTS];
  logic [TIME_WIDTH-1:0] left_q [NUM_SLOTS];
  logic [IW-1:0]  cur_q;
  logic           idle_q;
  logic [TIME_WIDTH-1:0] el_q;
  prrts_pkg::rule_e rule_q;
  logic           cur_ok_q;
  logic signed [prrts_pkg::EFF_W-1:0] best_q, self_q;
  logic           have_q, self_have_q, chosen_q;
  logic [IW-1:0]  chosen_idx_q;

  logic [TIME_WIDTH-1:0] st_t, el_t;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] sleep_sat;
  logic [IW-1:0] tslot;
  logic          t_in, tok, cur_ok_now;
  logic signed [15:0] np_clamp;

  assign st_t = TIME_WIDTH'(sleep_time_i);
  assign el_t = TIME_WIDTH'(elapsed_i);
  assign sum = {1'b0, st_t} + {1'b0, el_t};
  assign sleep_sat = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
  assign t_in  = 32'(target_slot_i) < NUM_SLOTS;
  assign tslot = IW'(target_slot_i);
  assign tok   = t_in && used_q[tslot];
  assign cur_ok_now = !idle_q && used_q[cur_q];

  always_comb begin
    np_clamp = new_priority_i;
    if (np_clamp > max_q) np_clamp = max_q;
    if (np_clamp < min_q) np_clamp = min_q;
  end

  // effective priority and runnable flag at the scan index
  logic signed [prrts_pkg::EFF_W-1:0] eff_i, eff_c;
  logic run_i, run_c;
  assign eff_i = prrts_pkg::EFF_W'(prio_q[idx_i])
               + (boost_q[idx_i] ? prrts_pkg::EFF_W'(prrts_pkg::BOOST_AMOUNT) : '0);
  assign eff_c = prrts_pkg::EFF_W'(prio_q[cur_q])
               + (boost_q[cur_q] ? prrts_pkg::EFF_W'(prrts_pkg::BOOST_AMOUNT) : '0);
  assign run_i = used_q[idx_i] && state_q[idx_i] == prrts_pkg::ST_RUNNING;
  assign run_c = used_q[cur_q] && state_q[cur_q] == prrts_pkg::ST_RUNNING;

  logic signed [prrts_pkg::EFF_W-1:0] best_fin;
  logic have_fin;
  assign have_fin = have_q || self_have_q;
  assign best_fin = have_q ? best_q : self_q;

  assign sts_o.quick = rule_q == prrts_pkg::RULE_CURRENT && cur_ok_q && run_c;

  // start the round robin after the current slot when it sits in the band
  logic start_cur;
  assign start_cur = cur_ok_q && run_c && eff_c == best_fin;

  // scan order index for round robin
  logic [IW-1:0] rr_idx;
  always_comb begin
    logic [IW:0] s;
    s = {1'b0, idx_i} + ((start_cur) ? {1'b0, cur_q} + 1'b1 : '0);
    if (s >= (IW+1)'(NUM_SLOTS)) s = s - (IW+1)'(NUM_SLOTS);
    rr_idx = s[IW-1:0];
  end

  logic signed [prrts_pkg::EFF_W-1:0] eff_r;
  logic run_r;
  assign eff_r = prrts_pkg::EFF_W'(prio_q[rr_idx])
               + (boost_q[rr_idx] ? prrts_pkg::EFF_W'(prrts_pkg::BOOST_AMOUNT) : '0);
  assign run_r = used_q[rr_idx] && state_q[rr_idx] == prrts_pkg::ST_RUNNING;

  assign sts_o.found = have_fin && run_r && eff_r == best_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= -16'sd512;
      max_q <= 16'sd512;
      used_q <= NUM_SLOTS'(1);
      boost_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_q[i] <= (i == 0) ? prrts_pkg::ST_RUNNING : prrts_pkg::ST_STOPPED;
        prio_q[i] <= '0;
        left_q[i] <= '0;
      end
      cur_q <= '0;
      idle_q <= 1'b0;
      el_q <= '0;
      rule_q <= prrts_pkg::RULE_CURRENT;
      cur_ok_q <= 1'b0;
      best_q <= '0; self_q <= '0;
      have_q <= 1'b0; self_have_q <= 1'b0; chosen_q <= 1'b0;
      chosen_idx_q <= '0;
      next_slot_o <= '0;
      run_idle_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == prrts_pkg::REG_MIN_PRIO) min_q <= cfg_data_i;
        else max_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        el_q <= el_t;
        have_q <= 1'b0; self_have_q <= 1'b0; chosen_q <= 1'b0;
        cur_ok_q <= cur_ok_now;
        rule_q <= prrts_pkg::RULE_CURRENT;
        case (op_i)
          prrts_pkg::OP_TICK:  rule_q <= prrts_pkg::RULE_ANY;
          prrts_pkg::OP_YIELD: rule_q <= prrts_pkg::RULE_OTHER;
          prrts_pkg::OP_START: begin
            rule_q <= prrts_pkg::RULE_ANY;
            if (tok && state_q[tslot] == prrts_pkg::ST_STOPPED)
              state_q[tslot] <= prrts_pkg::ST_RUNNING;
          end
          prrts_pkg::OP_STOP: begin
            rule_q <= prrts_pkg::RULE_ANY;
            if (tok && state_q[tslot] == prrts_pkg::ST_RUNNING)
              state_q[tslot] <= prrts_pkg::ST_STOPPED;
          end
          prrts_pkg::OP_SETPRIO: begin
            rule_q <= prrts_pkg::RULE_ANY;
            if (tok) begin
              prio_q[tslot] <= np_clamp;
              boost_q[tslot] <= 1'b0;
            end
          end
          prrts_pkg::OP_SLEEP: begin
            rule_q <= prrts_pkg::RULE_OTHER;
            if (cur_ok_now) begin
              state_q[cur_q] <= prrts_pkg::ST_SLEEPING;
              left_q[cur_q] <= sleep_sat;
            end
          end
          prrts_pkg::OP_EXIT: begin
            rule_q <= prrts_pkg::RULE_OTHER;
            if (cur_ok_now) state_q[cur_q] <= prrts_pkg::ST_FINISHED;
          end
          prrts_pkg::OP_CREATE: begin
            if (t_in && !used_q[tslot]) begin
              used_q[tslot] <= 1'b1;
              state_q[tslot] <= prrts_pkg::ST_STOPPED;
              prio_q[tslot] <= '0;
              boost_q[tslot] <= 1'b0;
              left_q[tslot] <= '0;
            end
          end
          prrts_pkg::OP_DESTROY: begin
            if (tok) begin
              used_q[tslot] <= 1'b0;
              state_q[tslot] <= prrts_pkg::ST_STOPPED;
              prio_q[tslot] <= '0;
              boost_q[tslot] <= 1'b0;
              left_q[tslot] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.cnt_step && used_q[idx_i] && state_q[idx_i] == prrts_pkg::ST_SLEEPING) begin
        if (left_q[idx_i] <= el_q) begin
          left_q[idx_i] <= '0;
          state_q[idx_i] <= prrts_pkg::ST_RUNNING;
          if (prio_q[idx_i] >= min_q && prio_q[idx_i] <= max_q) boost_q[idx_i] <= 1'b1;
        end else begin
          left_q[idx_i] <= left_q[idx_i] - el_q;
        end
      end
      if (cmd_i.best_step) begin
        if (run_i) begin
          if (rule_q == prrts_pkg::RULE_OTHER && cur_ok_q && idx_i == cur_q) begin
            self_q <= eff_i;
            self_have_q <= 1'b1;
          end else if (!have_q || eff_i > best_q) begin
            best_q <= eff_i;
            have_q <= 1'b1;
          end
        end
      end
      if (cmd_i.sel_step && sts_o.found && !chosen_q) begin
        chosen_q <= 1'b1;
        chosen_idx_q <= rr_idx;
      end
      if (cmd_i.finish) begin
        if (sts_o.quick || chosen_q) begin
          boost_q[sts_o.quick ? cur_q : chosen_idx_q] <= 1'b0;
          cur_q <= sts_o.quick ? cur_q : chosen_idx_q;
          idle_q <= 1'b0;
          next_slot_o <= 4'(sts_o.quick ? cur_q : chosen_idx_q);
          run_idle_o <= 1'b0;
        end else begin
          idle_q <= 1'b1;
          next_slot_o <= '0;
          run_idle_o <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/prrts_controller.sv
`timescale 1ns / 1ps
module prrts_controller #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  output prrts_pkg::cmd_t              cmd_o,
  output logic [$clog2(NUM_SLOTS)-1:0] idx_o,
  input  prrts_pkg::sts_t              sts_i,
  output logic                         done_o
);
  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;
  localparam logic [2:0] S_BEST = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic last;
  assign last = 32'(idx_q) == NUM_SLOTS - 1;
  assign idx_o = idx_q;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cmd_o = '0;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.load = 1'b1;
        state_d = S_CNT;
        idx_d = '0;
      end
      S_CNT: begin
        cmd_o.cnt_step = 1'b1;
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = sts_i.quick ? S_FIN : S_BEST;
      end
      S_BEST: begin
        cmd_o.best_step = 1'b1;
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end
endmodule

// File: sv/priority_round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// Flow: a taken start loads the event, then the slot scans run in order: countdown,
// band maximum, then round robin select; when keep-current holds the two pick scans are skipped.
// One event in flight at a time; a start is taken only while the block is idle.
// A finish step then commits the pick, and the result is registered before its strobe.
// Reset: asynchronous, active low; slot 0 occupied and running, limits -512/512.
// Results are strobed for one cycle; the receiver cannot stall.
module priority_round_robin_thread_scheduler #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op_i,
  input  logic [3:0]         target_slot_i,
  input  logic signed [15:0] new_priority_i,
  input  logic [31:0]        sleep_time_i,
  input  logic [31:0]        elapsed_i,
  output logic               result_valid_o,
  output logic [3:0]         next_slot_o,
  output logic               run_idle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
`include "priority_round_robin_thread_scheduler_defines.svh"

  prrts_pkg::cmd_t cmd;
  prrts_pkg::sts_t sts;
  logic [$clog2(NUM_SLOTS)-1:0] idx;
  logic done, done_q;

  // hold configuration off while an event is in flight or being taken
  assign cfg_ready_o = !busy && !start;

  prrts_controller #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .cmd_o(cmd), .idx_o(idx),
    .sts_i(sts), .done_o(done)
  );

  prrts_datapath #(.NUM_SLOTS(NUM_SLOTS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx), .sts_o(sts),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .op_i, .target_slot_i, .new_priority_i, .sleep_time_i,
    .elapsed_i, .next_slot_o, .run_idle_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= done;
  end
  assign result_valid_o = done_q;

  `PRRTS_ASSERT(a_no_accept_busy, (start && !busy) |=> busy, "start not taken")
  `PRRTS_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "strobe too long")
  `PRRTS_ASSERT(a_idle_slot_zero, (result_valid_o && run_idle_o) |-> next_slot_o == 4'd0,
                "idle result with nonzero slot")
endmodule
